// ----- rtl/core/tsp_min_tour_cost_defines.svh -----
// Assertion macros for the tour cost solver.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef TSP_MIN_TOUR_COST_DEFINES_SVH
`define TSP_MIN_TOUR_COST_DEFINES_SVH
`ifndef SYNTHESIS
`define TSP_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tsp_min_tour_cost: same-cycle check failed");
`define TSP_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tsp_min_tour_cost: next-cycle check failed");
`else
`define TSP_ASSERT_IMP(label, clk, rst, ante, cons)
`define TSP_ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

// ----- rtl/core/tsp_pkg.sv -----
// Shared constants and cost arithmetic for the tour cost solver.
// No dependencies.
package tsp_pkg;

  localparam int MAX_NODES_DEF = 8;
  localparam int COST_BITS_DEF = 10;

  localparam int CFG_W      = 4;
  localparam int NODE_IN_W  = 3;
  localparam int COST_IN_W  = 11;
  localparam int DP_W       = 17;
  localparam int RES_W      = 16;

  localparam logic [CFG_W-1:0] NODE_COUNT_RESET = CFG_W'(8);
  localparam logic [DP_W-1:0]  INF_COST         = {1'b1, {(DP_W-1){1'b0}}};
  localparam logic [RES_W-1:0] SAT_MAX          = {RES_W{1'b1}};

  // Negative raw cost means no edge; clip large costs to cmax.
  function automatic logic [DP_W-1:0] edge_cost(input logic [COST_IN_W-1:0] raw,
                                                input logic [DP_W-1:0]      cmax);
    logic [DP_W-1:0] v;
    v = DP_W'(raw[COST_IN_W-2:0]);
    if (raw[COST_IN_W-1]) begin
      return INF_COST;
    end
    return (v > cmax) ? cmax : v;
  endfunction

  // Infinity absorbs; finite sums saturate at SAT_MAX.
  function automatic logic [DP_W-1:0] sat_add(input logic [DP_W-1:0] a,
                                              input logic [DP_W-1:0] b);
    logic [DP_W:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    if (a[DP_W-1] || b[DP_W-1]) begin
      return INF_COST;
    end
    if (sum > (DP_W+1)'(SAT_MAX)) begin
      return DP_W'(SAT_MAX);
    end
    return sum[DP_W-1:0];
  endfunction

endpackage

// ----- rtl/core/tsp_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module tsp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/core/tsp_min_tour_cost.sv -----
// Held-Karp minimum tour cost over a loaded cost matrix; uses tsp_pkg and tsp_ram.
// Load: one matrix beat per cycle while busy is low. A beat with last set starts the
// solve, and busy stays high until it ends: each node outside a subset reads over its
// candidate nodes l and then writes once; a node inside the subset is only stepped past.
// The result strobe (done) comes in the first cycle with busy low; no stall.
// Reset (rst, synchronous) returns to idle and sets node_count to 8.
`include "tsp_min_tour_cost_defines.svh"

module tsp_min_tour_cost import tsp_pkg::*; #(
  parameter int MAX_NODES = MAX_NODES_DEF,
  parameter int COST_BITS = COST_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_W-1:0]      cfg_wdata,
  input  logic                  start,
  output logic                  busy,
  input  logic [NODE_IN_W-1:0]  row,
  input  logic [NODE_IN_W-1:0]  col,
  input  logic signed [COST_IN_W-1:0] cost,
  input  logic                  last,
  output logic                  done,
  output logic [RES_W-1:0]      min_cost,
  output logic                  no_tour
);

  localparam int NODE_W = $clog2(MAX_NODES);
  localparam int MAT_DEPTH = 1 << (2 * NODE_W);
  localparam int DP_DEPTH = (1 << NODE_W) << MAX_NODES;
  localparam logic [DP_W-1:0] CMAX = DP_W'((1 << COST_BITS) - 1);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_ISSUE = 3'b010,
    S_DRAIN = 3'b100
  } state_t;

  state_t                 state;
  logic [CFG_W-1:0]       node_count;
  logic [NODE_W-1:0]      n_last;
  logic [MAX_NODES-1:0]   s;
  logic [NODE_W-1:0]      i;
  logic [NODE_W-1:0]      l;
  logic                   fin;
  logic [DP_W-1:0]        best;
  logic                   pend;
  logic                   pend_base;

  logic                   load_fire;
  logic                   row_ok;
  logic                   mat_we;
  logic [2*NODE_W-1:0]    mat_waddr;
  logic [2*NODE_W-1:0]    mat_raddr;
  logic [COST_IN_W-1:0]   mat_rdata;
  logic                   dp_we;
  logic [NODE_W+MAX_NODES-1:0] dp_waddr;
  logic [NODE_W+MAX_NODES-1:0] dp_raddr;
  logic [DP_W-1:0]        dp_rdata;

  logic                   base;
  logic                   in_set;
  logic                   issue_go;
  logic                   l_done;
  logic [MAX_NODES-1:0]   full;
  logic [MAX_NODES-1:0]   s_next;
  logic [NODE_W-1:0]      i_next;
  logic                   fin_next;
  logic [NODE_W-1:0]      n_last_next;
  logic [DP_W-1:0]        edge_val;
  logic [DP_W-1:0]        cand;
  logic [DP_W-1:0]        best_upd;

  assign busy      = (state != S_IDLE);
  assign load_fire = start && !busy;
  assign row_ok    = (int'(row) < MAX_NODES) && (int'(col) < MAX_NODES);
  assign mat_we    = load_fire && row_ok;
  assign mat_waddr = {NODE_W'(row), NODE_W'(col)};

  assign base     = (s == '0);
  assign in_set   = s[i];
  assign issue_go = (state == S_ISSUE) && !in_set;
  assign l_done   = base || (l == n_last);

  // Read cost(i, l) and dp(l, s without l); the base row reads cost(i, 0).
  assign mat_raddr = {i, base ? NODE_W'(0) : l};
  assign dp_raddr  = {l, s & ~(MAX_NODES'(1) << l)};

  assign dp_we    = (state == S_DRAIN) && !fin;
  assign dp_waddr = {i, s};

  always_comb begin
    for (int b = 0; b < MAX_NODES; b++) begin
      full[b] = (b != 0) && (b <= int'(n_last));
    end
  end

  // Step to the next (subset, node) pair; after the full subset, run node 0.
  always_comb begin
    s_next   = s;
    i_next   = i + NODE_W'(1);
    fin_next = fin;
    if (i == n_last) begin
      if (s == full) begin
        fin_next = 1'b1;
        i_next   = '0;
      end else begin
        s_next = s + MAX_NODES'(2);
        i_next = NODE_W'(1);
      end
    end
  end

  always_comb begin
    int n_cl;
    n_cl = int'(node_count);
    if (n_cl < 2) begin
      n_cl = 2;
    end else if (n_cl > MAX_NODES) begin
      n_cl = MAX_NODES;
    end
    n_last_next = NODE_W'(n_cl - 1);
  end

  assign edge_val = edge_cost(mat_rdata, CMAX);
  assign cand     = pend_base ? edge_val : sat_add(edge_val, dp_rdata);
  assign best_upd = (pend && (cand < best)) ? cand : best;

  tsp_ram #(
    .WIDTH (COST_IN_W),
    .DEPTH (MAT_DEPTH)
  ) u_cost_ram (
    .clk   (clk),
    .we    (mat_we),
    .waddr (mat_waddr),
    .wdata (cost),
    .raddr (mat_raddr),
    .rdata (mat_rdata)
  );

  tsp_ram #(
    .WIDTH (DP_W),
    .DEPTH (DP_DEPTH)
  ) u_dp_ram (
    .clk   (clk),
    .we    (dp_we),
    .waddr (dp_waddr),
    .wdata (best_upd),
    .raddr (dp_raddr),
    .rdata (dp_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      node_count <= NODE_COUNT_RESET;
      done       <= 1'b0;
      pend       <= 1'b0;
    end else begin
      if (cfg_we) begin
        node_count <= cfg_wdata;
      end
      done      <= 1'b0;
      pend      <= issue_go && (base || s[l]);
      pend_base <= base;
      case (state)
        S_IDLE: begin
          if (load_fire && last) begin
            n_last <= n_last_next;
            s      <= '0;
            i      <= NODE_W'(1);
            l      <= NODE_W'(1);
            fin    <= 1'b0;
            best   <= INF_COST;
            state  <= S_ISSUE;
          end
        end
        S_ISSUE: begin
          best <= best_upd;
          if (in_set) begin
            s   <= s_next;
            i   <= i_next;
            fin <= fin_next;
            l   <= NODE_W'(1);
          end else if (l_done) begin
            state <= S_DRAIN;
          end else begin
            l <= l + NODE_W'(1);
          end
        end
        S_DRAIN: begin
          best <= INF_COST;
          if (fin) begin
            done     <= 1'b1;
            no_tour  <= best_upd[DP_W-1];
            min_cost <= best_upd[DP_W-1] ? '0 : best_upd[RES_W-1:0];
            state    <= S_IDLE;
          end else begin
            // Hold reads in this state so the write lands before the next issue.
            s     <= s_next;
            i     <= i_next;
            fin   <= fin_next;
            l     <= NODE_W'(1);
            state <= S_ISSUE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `TSP_ASSERT_NXT(a_last_starts, clk, rst, load_fire && last, busy)
  `TSP_ASSERT_NXT(a_done_after_final, clk, rst, (state == S_DRAIN) && fin, done && !busy)
  `TSP_ASSERT_IMP(a_no_tour_zero, clk, rst, done && no_tour, min_cost == '0)
  `TSP_ASSERT_IMP(a_dp_write_outside_set, clk, rst, dp_we, !s[i] && (i != '0))

endmodule

// ----- sim/tb_top.sv -----
// Self-checking testbench for tsp_min_tour_cost: loads random cost matrices, runs tour
// solves over many node counts and compares each result with an in-bench Held-Karp solver.
// Depends on tsp_pkg and the tsp_min_tour_cost RTL.
module tb_top import tsp_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NODES      = MAX_NODES_DEF;
  localparam int ITEM_COUNT = 1650;
  localparam int QUIET_FROM = 1400;
  localparam logic [DP_W-1:0]      CMAX    = DP_W'((1 << COST_BITS_DEF) - 1);
  localparam logic [COST_IN_W-1:0] NO_EDGE = '1;

  typedef struct packed {
    logic [RES_W-1:0] min_cost;
    logic             no_tour;
  } tour_t;

  class tour_cost_board;
    logic [COST_IN_W-1:0] edge_mem [NODES][NODES];
    logic [DP_W-1:0]      path_cost [NODES][1 << NODES];
    logic [CFG_W-1:0]     node_count;
    tour_t                pending_tours [$];
    int                   errors;

    function new();
      node_count = NODE_COUNT_RESET;
      errors = 0;
    endfunction

    function void set_node_count(logic [CFG_W-1:0] v);
      node_count = v;
    endfunction

    function int waiting();
      return pending_tours.size();
    endfunction

    // Any negative cost is a missing edge.
    function logic [DP_W-1:0] link_cost(int src, int dst);
      logic [COST_IN_W-1:0] raw;
      raw = edge_mem[src][dst];
      if (raw[COST_IN_W-1]) return INF_COST;
      if (DP_W'(raw[COST_IN_W-2:0]) > CMAX) return CMAX;
      return DP_W'(raw[COST_IN_W-2:0]);
    endfunction

    function logic [DP_W-1:0] path_sum(logic [DP_W-1:0] a, logic [DP_W-1:0] b);
      logic [DP_W:0] sum;
      if (a[DP_W-1] || b[DP_W-1]) return INF_COST;
      sum = a + b;
      if (sum > (DP_W+1)'(SAT_MAX)) return DP_W'(SAT_MAX);
      return sum[DP_W-1:0];
    endfunction

    // path_cost[i][s]: cheapest path from i through all of s back to node 0.
    function logic [DP_W-1:0] cheapest_tour();
      int n, full, s, i, l;
      logic [DP_W-1:0] best, v;
      n = node_count;
      if (n < 2) n = 2;
      if (n > NODES) n = NODES;
      full = ((1 << n) - 1) & ~1;
      for (s = 0; s <= full; s += 2) begin
        for (i = 1; i < n; i++) begin
          if ((s >> i) & 1) continue;
          if (s == 0) begin
            best = link_cost(i, 0);
          end else begin
            best = INF_COST;
            for (l = 1; l < n; l++) begin
              if (((s >> l) & 1) == 0) continue;
              v = path_sum(link_cost(i, l), path_cost[l][s & ~(1 << l)]);
              if (v < best) best = v;
            end
          end
          path_cost[i][s] = best;
        end
      end
      best = INF_COST;
      for (l = 1; l < n; l++) begin
        v = path_sum(link_cost(0, l), path_cost[l][full & ~(1 << l)]);
        if (v < best) best = v;
      end
      return best;
    endfunction

    function void note_entry(logic [NODE_IN_W-1:0] r, logic [NODE_IN_W-1:0] c,
                             logic [COST_IN_W-1:0] w, logic lst);
      tour_t t;
      logic [DP_W-1:0] best;
      edge_mem[r][c] = w;
      if (!lst) return;
      best = cheapest_tour();
      t.no_tour  = best[DP_W-1];
      t.min_cost = best[DP_W-1] ? '0 : best[RES_W-1:0];
      pending_tours.push_back(t);
    endfunction

    function void check_tour(logic [RES_W-1:0] mc, logic nt);
      tour_t t;
      if (pending_tours.size() == 0) begin
        $error("unexpected result: min_cost=%0d no_tour=%0b", mc, nt);
        errors++;
        return;
      end
      t = pending_tours.pop_front();
      if (mc !== t.min_cost) begin
        $error("min_cost: expected %0d, actual %0d", t.min_cost, mc);
        errors++;
      end
      if (nt !== t.no_tour) begin
        $error("no_tour: expected %0b, actual %0b", t.no_tour, nt);
        errors++;
      end
    endfunction
  endclass

  logic                        clk = 1'b0;
  logic                        rst;
  logic                        cfg_we;
  logic [CFG_W-1:0]            cfg_wdata;
  logic                        start;
  logic                        busy;
  logic [NODE_IN_W-1:0]        row;
  logic [NODE_IN_W-1:0]        col;
  logic signed [COST_IN_W-1:0] cost;
  logic                        last;
  logic                        done;
  logic [RES_W-1:0]            min_cost;
  logic                        no_tour;

  tour_cost_board board;
  int sent = 0;
  bit gaps_on = 1'b0;

  tsp_min_tour_cost u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .start     (start),
    .busy      (busy),
    .row       (row),
    .col       (col),
    .cost      (cost),
    .last      (last),
    .done      (done),
    .min_cost  (min_cost),
    .no_tour   (no_tour)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Sample pre-edge values of every port at each rising edge.
  always @(posedge clk) begin
    if (!rst) begin
      if (done) board.check_tour(min_cost, no_tour);
      if (cfg_we) board.set_node_count(cfg_wdata);
      if (start && !busy) board.note_entry(row, col, cost, last);
    end
  end

  task automatic hold_off(input int cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  task automatic send_entry(input logic [NODE_IN_W-1:0] r, input logic [NODE_IN_W-1:0] c,
                            input logic [COST_IN_W-1:0] w, input logic lst);
    start <= 1'b1;
    row   <= r;
    col   <= c;
    cost  <= w;
    last  <= lst;
    do @(posedge clk); while (busy);
    sent++;
    if (gaps_on && sent < QUIET_FROM && $urandom_range(0, 3) == 0)
      hold_off($urandom_range(1, 7));
  endtask

  // Write only with nothing in flight and the solver idle.
  task automatic set_nodes(input logic [CFG_W-1:0] v);
    start <= 1'b0;
    do @(posedge clk); while (board.waiting() != 0 || busy);
    repeat (8) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic send_random(input int n, input logic lst);
    logic [NODE_IN_W-1:0] r, c;
    logic [COST_IN_W-1:0] w;
    int pick;
    // Mostly entries inside the active square; the rest land anywhere.
    if ($urandom_range(0, 9) < 8) begin
      r = NODE_IN_W'($urandom_range(0, n - 1));
      c = NODE_IN_W'($urandom_range(0, n - 1));
    end else begin
      r = NODE_IN_W'($urandom_range(0, NODES - 1));
      c = NODE_IN_W'($urandom_range(0, NODES - 1));
    end
    pick = $urandom_range(0, 19);
    if (pick <= 12)      w = COST_IN_W'($urandom_range(0, 1023));
    else if (pick <= 14) w = COST_IN_W'($urandom_range(0, 15));
    else if (pick == 15) w = COST_IN_W'(1023);
    else if (pick <= 17) w = NO_EDGE;
    else                 w = COST_IN_W'($urandom_range(1024, 2047));
    send_entry(r, c, w, lst);
  endtask

  initial begin
    int n_eff, pick, tours, extra, phase;
    logic [CFG_W-1:0] nv;
    board     = new();
    rst       = 1'b1;
    start     = 1'b0;
    cfg_we    = 1'b0;
    cfg_wdata = '0;
    row       = '0;
    col       = '0;
    cost      = '0;
    last      = 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Fill the whole matrix first so no unwritten entry is ever read; solve at reset count.
    gaps_on = 1'b1;
    for (int r = 0; r < NODES; r++)
      for (int c = 0; c < NODES; c++)
        send_entry(NODE_IN_W'(r), NODE_IN_W'(c), COST_IN_W'($urandom_range(0, 1023)),
                   (r == NODES - 1) && (c == NODES - 1));

    set_nodes(2);
    send_entry(0, 1, 0, 0);
    send_entry(1, 0, 0, 1);
    send_entry(7, 7, NO_EDGE, 0);
    send_entry(5, 2, COST_IN_W'(1024), 0);
    send_entry(0, 1, 1023, 0);
    send_entry(1, 0, 1023, 1);
    send_entry(1, 0, NO_EDGE, 1);
    send_entry(1, 0, COST_IN_W'(2043), 1);
    send_entry(1, 0, 7, 0);
    send_entry(0, 1, COST_IN_W'(1024), 1);
    send_entry(0, 1, 3, 1);
    set_nodes(0);
    send_entry(0, 1, 1, 1);
    set_nodes(1);
    send_entry(1, 0, 2, 1);
    set_nodes(15);
    send_entry(7, 7, 0, 1);
    set_nodes(9);
    send_entry(3, 4, 1023, 1);
    set_nodes(8);
    send_entry(0, 7, NO_EDGE, 1);

    n_eff = NODES;
    phase = 0;
    while (sent < ITEM_COUNT) begin
      // Small graphs dominate; full size and clamped counts are rare since they are slow.
      pick = $urandom_range(0, 99);
      if (pick < 4) nv = ($urandom_range(0, 1) == 0) ? CFG_W'($urandom_range(0, 1))
                                                    : CFG_W'($urandom_range(9, 15));
      else if (pick < 12) nv = CFG_W'(NODES);
      else if (pick < 25) nv = CFG_W'($urandom_range(6, 7));
      else                nv = CFG_W'($urandom_range(2, 5));
      if (phase == 0 || $urandom_range(0, 2) != 0) begin
        set_nodes(nv);
        n_eff = (nv < 2) ? 2 : (nv > NODES) ? NODES : nv;
      end
      gaps_on = ($urandom_range(0, 2) != 0);
      tours = $urandom_range(1, 4);
      for (int t = 0; t < tours; t++) begin
        extra = $urandom_range(0, 10);
        for (int k = 0; k < extra; k++) send_random(n_eff, 1'b0);
        send_random(n_eff, 1'b1);
      end
      phase++;
    end

    start <= 1'b0;
    do @(posedge clk); while (board.waiting() != 0 || busy);
    repeat (64) @(posedge clk);
    if (board.waiting() != 0) begin
      $error("%0d expected results never arrived", board.waiting());
      board.errors++;
    end
    if (board.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    repeat (2000) #1_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule

// ----- tsp_min_tour_cost.f -----
+incdir+rtl/core
rtl/core/tsp_pkg.sv
rtl/core/tsp_ram.sv
rtl/core/tsp_min_tour_cost.sv
sim/tb_top.sv
